[src/ps2dec_pkg.sv]
// Package with the beat types, codes and scan code table of the PS/2 decoder.
`default_nettype none
package ps2dec_pkg;

	localparam logic       KIND_SCAN    = 1'b0;
	localparam logic       KIND_READ    = 1'b1;
	localparam logic [7:0] BREAK_PREFIX = 8'hF0;

	typedef struct packed {
		logic       kind;
		logic [7:0] scan_code;
	} in_beat_t;

	typedef struct packed {
		logic [6:0] taken_char;
		logic       char_taken;
		logic       char_pending;
	} out_beat_t;

	function automatic logic [6:0] map_code(input logic [7:0] code);
		logic [6:0] ch;
		begin
			case (code)
				8'h1C: ch = 7'h41; 8'h32: ch = 7'h42; 8'h21: ch = 7'h43;
				8'h23: ch = 7'h44; 8'h24: ch = 7'h45; 8'h2B: ch = 7'h46;
				8'h34: ch = 7'h47; 8'h33: ch = 7'h48; 8'h43: ch = 7'h49;
				8'h3B: ch = 7'h4A; 8'h42: ch = 7'h4B; 8'h4B: ch = 7'h4C;
				8'h3A: ch = 7'h4D; 8'h31: ch = 7'h4E; 8'h44: ch = 7'h4F;
				8'h4D: ch = 7'h50; 8'h15: ch = 7'h51; 8'h2D: ch = 7'h52;
				8'h1B: ch = 7'h53; 8'h2C: ch = 7'h54; 8'h3C: ch = 7'h55;
				8'h2A: ch = 7'h56; 8'h1D: ch = 7'h57; 8'h22: ch = 7'h58;
				8'h35: ch = 7'h59; 8'h1A: ch = 7'h5A;
				8'h45: ch = 7'h30; 8'h16: ch = 7'h31; 8'h1E: ch = 7'h32;
				8'h26: ch = 7'h33; 8'h25: ch = 7'h34; 8'h2E: ch = 7'h35;
				8'h36: ch = 7'h36; 8'h3D: ch = 7'h37; 8'h3E: ch = 7'h38;
				8'h46: ch = 7'h39;
				8'h29: ch = 7'h20;
				8'h5A: ch = 7'h0A;
				8'h66: ch = 7'h08;
				default: ch = 7'h00;
			endcase
			return ch;
		end
	endfunction

endpackage
`default_nettype wire

[src/ps2dec_core.sv]
// Decoder state and the single-pass next-state and result logic.
`default_nettype none
module ps2dec_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire ps2dec_pkg::in_beat_t item,
	output ps2dec_pkg::out_beat_t     result
);

	logic       break_armed_q;
	logic [7:0] remembered_code_q;
	logic       repeat_swallowed_q;
	logic [6:0] held_char_q;
	logic       held_valid_q;

	logic       break_armed_d;
	logic [7:0] remembered_code_d;
	logic       repeat_swallowed_d;
	logic [6:0] held_char_d;
	logic       held_valid_d;
	logic [6:0] mapped;
	logic       taken;

	assign mapped = ps2dec_pkg::map_code(item.scan_code);

	always_comb begin
		break_armed_d      = break_armed_q;
		remembered_code_d  = remembered_code_q;
		repeat_swallowed_d = repeat_swallowed_q;
		held_char_d        = held_char_q;
		held_valid_d       = held_valid_q;
		taken              = 1'b0;
		if (item.kind == ps2dec_pkg::KIND_SCAN) begin
			if (item.scan_code == ps2dec_pkg::BREAK_PREFIX) begin
				break_armed_d = 1'b1;
			end else if (break_armed_q) begin
				break_armed_d = 1'b0;
				if (item.scan_code == remembered_code_q) begin
					remembered_code_d  = 8'h00;
					repeat_swallowed_d = 1'b0;
				end
			end else if (item.scan_code == remembered_code_q && !repeat_swallowed_q) begin
				repeat_swallowed_d = 1'b1;
			end else begin
				remembered_code_d  = item.scan_code;
				repeat_swallowed_d = 1'b0;
				if (mapped != 7'h00) begin
					held_char_d  = mapped;
					held_valid_d = 1'b1;
				end
			end
		end else if (held_valid_q) begin
			taken        = 1'b1;
			held_valid_d = 1'b0;
		end
	end

	assign result.taken_char   = taken ? held_char_q : 7'h00;
	assign result.char_taken   = taken;
	assign result.char_pending = held_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_armed_q      <= 1'b0;
			remembered_code_q  <= 8'h00;
			repeat_swallowed_q <= 1'b0;
			held_char_q        <= 7'h00;
			held_valid_q       <= 1'b0;
		end else if (en) begin
			break_armed_q      <= break_armed_d;
			remembered_code_q  <= remembered_code_d;
			repeat_swallowed_q <= repeat_swallowed_d;
			held_char_q        <= held_char_d;
			held_valid_q       <= held_valid_d;
		end
	end

endmodule
`default_nettype wire

[src/ps2_scancode_to_ascii_decoder.sv]
// Top level of the PS/2 set-2 scan code decoder with a one-character buffer.
//
//   channel  direction  handshake                     payload
//   item     in         item_valid / item_stall       kind, scan_code
//   result   out        result_valid / result_stall   taken_char, char_taken, char_pending
//
// Each beat passes an input register and a result register; the result register
// captures the output of the decode logic for the beat held in the input register.
// The rate is one beat a cycle, set by the decode logic, while the result is not stalled.
// Reset clears the decoder state and empties both registers.
// A stalled result holds the input register, which then stalls the item channel.
`default_nettype none
module ps2_scancode_to_ascii_decoder (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire ps2dec_pkg::in_beat_t  item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output ps2dec_pkg::out_beat_t      result
);

	logic                  valid_s1;
	ps2dec_pkg::in_beat_t  item_s1;
	logic                  advance;
	ps2dec_pkg::out_beat_t result_d;
	ps2dec_pkg::out_beat_t result_q;
	logic                  result_valid_q;

	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	ps2dec_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.item   (item_s1),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_taken_has_char: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.char_taken |-> result.taken_char != 7'h00)
		else $error("taken character is zero");

	a_no_take_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.char_taken |-> result.taken_char == 7'h00)
		else $error("character shown without a read");

	a_take_empties: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.char_taken |-> !result.char_pending)
		else $error("buffer still full after a read");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> valid_s1 && $stable(item_s1))
		else $error("input register changed while stalled");

endmodule
`default_nettype wire
